[rtl/pcti_pkg.sv]
// ----------------------------------------------------------------------------
// pcti_pkg
// Shared widths and codes for the periodic cubic table interpolator.
// ----------------------------------------------------------------------------
package pcti_pkg;

  localparam int VAL_W     = 32;  // table sample, Q16.16
  localparam int FRAC_W    = 16;  // fractional bits of a position
  localparam int INT_W     = 16;  // integer bits of a position
  localparam int IDX_W     = 14;  // write index
  localparam int CFG_W     = 13;  // period register
  localparam int OUT_W     = 34;  // saturated result
  localparam int ACC_W     = 40;  // Horner accumulator
  localparam int STEP_BITS = 4;   // remainder bits resolved per stage
  localparam int BANKS     = 4;   // interleaved table banks

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

endpackage

[rtl/pcti_mod_pipe.sv]
// ----------------------------------------------------------------------------
// pcti_mod_pipe
// Pipelined restoring remainder of an unsigned integer by the period.
// ----------------------------------------------------------------------------
module pcti_mod_pipe #(
  parameter int KW = 14
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [pcti_pkg::INT_W-1:0] mag,
  input  logic [KW-1:0]             period,
  output logic [KW-1:0]             rem
);

  localparam int NSTG = pcti_pkg::INT_W / pcti_pkg::STEP_BITS;

  logic [KW-1:0]              rem_r [NSTG];
  logic [pcti_pkg::INT_W-1:0] mag_r [NSTG];

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    logic [KW-1:0]              rem_in;
    logic [pcti_pkg::INT_W-1:0] mag_in;
    logic [KW-1:0]              rem_nxt;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign mag_in = mag;
    end else begin : g_rest
      assign rem_in = rem_r[i-1];
      assign mag_in = mag_r[i-1];
    end

    always_comb begin
      logic [KW:0] t;
      logic [pcti_pkg::STEP_BITS-1:0] bits;
      bits = mag_in[pcti_pkg::INT_W-1-pcti_pkg::STEP_BITS*i -: pcti_pkg::STEP_BITS];
      rem_nxt = rem_in;
      for (int j = pcti_pkg::STEP_BITS - 1; j >= 0; j--) begin
        t = {rem_nxt, bits[j]};
        if (t >= {1'b0, period}) begin
          t = t - {1'b0, period};
        end
        rem_nxt = t[KW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        mag_r[i] <= mag_in;
      end
    end
  end

  assign rem = rem_r[NSTG-1];

endmodule

[rtl/periodic_cubic_table_interpolator.sv]
// ----------------------------------------------------------------------------
// periodic_cubic_table_interpolator
// Catmull-Rom interpolation over a periodic Q16.16 sample table.
// ----------------------------------------------------------------------------
// One item enters per clock and results stream out one per clock; an evaluate
// item's result passes every stage below to the output register, a write item
// gives no result. The whole pipeline advances together and halts only while a
// result sits in the output register with out_stall high. The table lives in
// four interleaved single-port-read banks (entry e in bank e mod 4), so the
// four neighbors of any position are read together. Writes travel down the
// same pipeline and hit the table at the read stage, so a later evaluate
// always sees an earlier write. The table is undefined until written; entry 0
// is the wrap entry before sample 0 and the two entries after the last sample
// wrap the start. Position wrapping uses a 4-stage remainder unit.
// ----------------------------------------------------------------------------
module periodic_cubic_table_interpolator #(
  parameter int TABLE_POINTS = 8192
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic [pcti_pkg::IDX_W-1:0]        in_entry_index,
  input  logic signed [pcti_pkg::VAL_W-1:0] in_entry_value,
  input  logic signed [pcti_pkg::VAL_W-1:0] in_position,
  // results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pcti_pkg::OUT_W-1:0] out_interpolated_value,
  // period register
  input  logic                              cfg_wr_en,
  input  logic [pcti_pkg::CFG_W-1:0]        cfg_period_steps
);

  localparam int DEPTH      = TABLE_POINTS + 4;
  localparam int BANK_DEPTH = (DEPTH + 3) / 4;
  localparam int ROW_W      = $clog2(BANK_DEPTH);
  localparam int SUM_W      = ROW_W + 2;
  localparam int KW         = $clog2(TABLE_POINTS + 2);
  localparam int P_MAX      = TABLE_POINTS + 1;
  localparam int P_RESET    = (8191 < P_MAX) ? 8191 : P_MAX;
  localparam int NDIV       = pcti_pkg::INT_W / pcti_pkg::STEP_BITS;
  localparam int AW         = pcti_pkg::ACC_W;
  localparam int PW         = AW + pcti_pkg::FRAC_W + 1;
  localparam logic signed [PW-1:0] HALF16 = PW'(32768);

  // ---------------- period register (clamped on write) ----------------
  logic [KW-1:0] period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= KW'(P_RESET);
    end else if (cfg_wr_en) begin
      if (32'(cfg_period_steps) < 32'd4) begin
        period_r <= KW'(4);
      end else if (32'(cfg_period_steps) > 32'(P_MAX)) begin
        period_r <= KW'(P_MAX);
      end else begin
        period_r <= KW'(cfg_period_steps);
      end
    end
  end

  // ---------------- global advance ----------------
  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // ---------------- stage 0: capture ----------------
  logic                               v0_r, func0_r, neg0_r;
  logic [pcti_pkg::IDX_W-1:0]         idx0_r;
  logic [pcti_pkg::VAL_W-1:0]         val0_r;
  logic [pcti_pkg::FRAC_W-1:0]        frac0_r;
  logic [pcti_pkg::INT_W-1:0]         mag0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func0_r <= in_func;
      idx0_r  <= in_entry_index;
      val0_r  <= in_entry_value;
      frac0_r <= in_position[pcti_pkg::FRAC_W-1:0];
      neg0_r  <= in_position[pcti_pkg::VAL_W-1];
      // magnitude of the signed integer part; -32768 maps to 32768
      mag0_r  <= in_position[pcti_pkg::VAL_W-1]
                 ? pcti_pkg::INT_W'(0) - in_position[pcti_pkg::VAL_W-1 -: pcti_pkg::INT_W]
                 : in_position[pcti_pkg::VAL_W-1 -: pcti_pkg::INT_W];
    end
  end

  // ---------------- remainder unit and matching side pipe ----------------
  logic [KW-1:0] rem;

  pcti_mod_pipe #(.KW(KW)) u_mod (
    .clk    (clk),
    .en     (en),
    .mag    (mag0_r),
    .period (period_r),
    .rem    (rem)
  );

  logic                        dv_r    [NDIV];
  logic                        dfunc_r [NDIV];
  logic                        dneg_r  [NDIV];
  logic [pcti_pkg::IDX_W-1:0]  didx_r  [NDIV];
  logic [pcti_pkg::VAL_W-1:0]  dval_r  [NDIV];
  logic [pcti_pkg::FRAC_W-1:0] dfrac_r [NDIV];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NDIV; i++) dv_r[i] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= v0_r;
      for (int i = 1; i < NDIV; i++) dv_r[i] <= dv_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dfunc_r[0] <= func0_r;
      dneg_r[0]  <= neg0_r;
      didx_r[0]  <= idx0_r;
      dval_r[0]  <= val0_r;
      dfrac_r[0] <= frac0_r;
      for (int i = 1; i < NDIV; i++) begin
        dfunc_r[i] <= dfunc_r[i-1];
        dneg_r[i]  <= dneg_r[i-1];
        didx_r[i]  <= didx_r[i-1];
        dval_r[i]  <= dval_r[i-1];
        dfrac_r[i] <= dfrac_r[i-1];
      end
    end
  end

  // ---------------- stage a: wrapped index k ----------------
  logic                        va_r, funca_r;
  logic [KW-1:0]               ka_r;
  logic [pcti_pkg::IDX_W-1:0]  idxa_r;
  logic [pcti_pkg::VAL_W-1:0]  vala_r;
  logic [pcti_pkg::FRAC_W-1:0] fraca_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= dv_r[NDIV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      funca_r <= dfunc_r[NDIV-1];
      idxa_r  <= didx_r[NDIV-1];
      vala_r  <= dval_r[NDIV-1];
      fraca_r <= dfrac_r[NDIV-1];
      // floor modulo: a negative integer part folds back from the period
      ka_r    <= (dneg_r[NDIV-1] && rem != '0) ? period_r - rem : rem;
    end
  end

  // ---------------- banked table: write or read ----------------
  logic wr_ok;
  logic [pcti_pkg::VAL_W-1:0] rd_r [pcti_pkg::BANKS];

  assign wr_ok = va_r && funca_r == pcti_pkg::FUNC_WRITE && 32'(idxa_r) < 32'(DEPTH);

  for (genvar b = 0; b < pcti_pkg::BANKS; b++) begin : g_bank
    logic [pcti_pkg::VAL_W-1:0] mem [BANK_DEPTH];
    logic [1:0]       off;
    logic [SUM_W-1:0] ent;
    logic [ROW_W-1:0] rrow;
    logic [ROW_W-1:0] wrow;
    logic             we;

    // entry among k..k+3 that falls in this bank
    assign off  = 2'(b) - ka_r[1:0];
    assign ent  = SUM_W'(ka_r) + SUM_W'(off);
    assign rrow = ent[SUM_W-1:2];
    assign wrow = ROW_W'(idxa_r >> 2);
    assign we   = wr_ok && idxa_r[1:0] == 2'(b);

    always_ff @(posedge clk) begin
      if (en) begin
        if (we) begin
          mem[wrow] <= vala_r;
        end
        rd_r[b] <= mem[rrow];
      end
    end
  end

  logic                        vm_r;
  logic [1:0]                  klo_m_r;
  logic [pcti_pkg::FRAC_W-1:0] fracm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (en) begin
      vm_r <= va_r && funca_r == pcti_pkg::FUNC_EVAL;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      klo_m_r <= ka_r[1:0];
      fracm_r <= fraca_r;
    end
  end

  // ---------------- stage c: doubled Catmull-Rom coefficients ----------------
  logic signed [AW-1:0] p0, p1, p2, p3;
  logic signed [AW-1:0] c3_nxt, c2_nxt, c1_nxt, c0_nxt;

  assign p0 = AW'($signed(rd_r[klo_m_r]));
  assign p1 = AW'($signed(rd_r[2'(klo_m_r + 2'd1)]));
  assign p2 = AW'($signed(rd_r[2'(klo_m_r + 2'd2)]));
  assign p3 = AW'($signed(rd_r[2'(klo_m_r + 2'd3)]));

  assign c3_nxt = p3 - p0 + 3 * (p1 - p2);
  assign c2_nxt = 2 * p0 - 5 * p1 + 4 * p2 - p3;
  assign c1_nxt = p2 - p0;
  assign c0_nxt = 2 * p1;

  logic                        vc_r;
  logic signed [AW-1:0]        c3_r, c2c_r, c1c_r, c0c_r;
  logic [pcti_pkg::FRAC_W-1:0] fracc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_r    <= c3_nxt;
      c2c_r   <= c2_nxt;
      c1c_r   <= c1_nxt;
      c0c_r   <= c0_nxt;
      fracc_r <= fracm_r;
    end
  end

  // ---------------- Horner chain: multiply, then round and add ----------------
  logic signed [pcti_pkg::FRAC_W:0] fs;
  logic v1_r, w1_r, v2_r, w2_r, v3_r, w3_r;
  logic signed [PW-1:0] prod1_r, prod2_r, prod3_r;
  logic signed [AW-1:0] s1_r, s2_r, s3_r;
  logic signed [AW-1:0] c2_1_r, c1_1_r, c1_2_r, c1_3_r, c0_1_r, c0_2_r, c0_3_r;
  logic signed [AW-1:0] c0_4_r, c0_5_r;
  logic [pcti_pkg::FRAC_W-1:0] f1_r, f2_r, f3_r, f4_r;

  assign fs = $signed({1'b0, fracc_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      w1_r <= 1'b0;
      v2_r <= 1'b0;
      w2_r <= 1'b0;
      v3_r <= 1'b0;
      w3_r <= 1'b0;
    end else if (en) begin
      v1_r <= vc_r;
      w1_r <= v1_r;
      v2_r <= w1_r;
      w2_r <= v2_r;
      v3_r <= w2_r;
      w3_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // c3 * f
      prod1_r <= c3_r * fs;
      c2_1_r  <= c2c_r;
      c1_1_r  <= c1c_r;
      c0_1_r  <= c0c_r;
      f1_r    <= fracc_r;
      // s1 = c2 + R16(c3 f)
      s1_r    <= c2_1_r + AW'((prod1_r + HALF16) >>> pcti_pkg::FRAC_W);
      c1_2_r  <= c1_1_r;
      c0_2_r  <= c0_1_r;
      f2_r    <= f1_r;
      // s1 * f
      prod2_r <= s1_r * $signed({1'b0, f2_r});
      c1_3_r  <= c1_2_r;
      c0_3_r  <= c0_2_r;
      f3_r    <= f2_r;
      // s2 = c1 + R16(s1 f)
      s2_r    <= c1_3_r + AW'((prod2_r + HALF16) >>> pcti_pkg::FRAC_W);
      c0_4_r  <= c0_3_r;
      f4_r    <= f3_r;
      // s2 * f
      prod3_r <= s2_r * $signed({1'b0, f4_r});
      c0_5_r  <= c0_4_r;
      // s3 = c0 + R16(s2 f)
      s3_r    <= c0_5_r + AW'((prod3_r + HALF16) >>> pcti_pkg::FRAC_W);
    end
  end

  // ---------------- halve, saturate, output register ----------------
  localparam logic signed [AW-1:0] Y_HI = AW'((64'sd1 <<< (pcti_pkg::OUT_W - 1)) - 1);
  localparam logic signed [AW-1:0] Y_LO = AW'(-(64'sd1 <<< (pcti_pkg::OUT_W - 1)));

  logic signed [AW-1:0]             y_full;
  logic signed [pcti_pkg::OUT_W-1:0] y_sat;

  assign y_full = (s3_r + AW'(1)) >>> 1;

  always_comb begin
    if (y_full > Y_HI) begin
      y_sat = Y_HI[pcti_pkg::OUT_W-1:0];
    end else if (y_full < Y_LO) begin
      y_sat = Y_LO[pcti_pkg::OUT_W-1:0];
    end else begin
      y_sat = y_full[pcti_pkg::OUT_W-1:0];
    end
  end

  logic signed [pcti_pkg::OUT_W-1:0] out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= w3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r <= y_sat;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_interpolated_value = out_value_r;

endmodule
